FILE: sv/opa_pkg.sv
// Shared constants, codes and types for the object pool allocator.
package opa_pkg;

    // Default number of slots in the link memories
    localparam int DEFAULT_POOL_DEPTH = 32;

    // Slot count register value after reset (saturated to the pool depth)
    localparam int ITEM_COUNT_RESET = 32;

    localparam int CMD_W = 2;
    localparam int ST_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_FREED = 2'd3;

    // Write enables from the sequencer to the link memories
    typedef struct packed {
        logic next_we;
        logic prev_we;
    } opa_wr_en_t;

endpackage

FILE: sv/opa_link_mem.sv
// Next-link and prev-link memories with one write port and one registered read port each.
module opa_link_mem #(
    parameter int POOL_DEPTH = opa_pkg::DEFAULT_POOL_DEPTH,
    localparam int IDX_W = $clog2(POOL_DEPTH),
    localparam int LNK_W = $clog2(POOL_DEPTH + 1)
) (
    input  logic                 clk,
    input  opa_pkg::opa_wr_en_t  wr_en,
    input  logic [IDX_W-1:0]     next_addr,
    input  logic [LNK_W-1:0]     next_wdata,
    input  logic [IDX_W-1:0]     prev_addr,
    input  logic [LNK_W:0]       prev_wdata,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [LNK_W-1:0]     rd_next,
    output logic [LNK_W:0]       rd_prev
);
    import opa_pkg::*;

    // Successor of each slot on its list
    logic [LNK_W-1:0] next_mem [POOL_DEPTH];
    // Taken flag above the predecessor of each slot
    logic [LNK_W:0]   prev_mem [POOL_DEPTH];

    logic [LNK_W-1:0] rd_next_reg;
    logic [LNK_W:0]   rd_prev_reg;

    // Write next links
    always_ff @(posedge clk)
    begin
        if (wr_en.next_we)
        begin
            next_mem[next_addr] <= next_wdata;
        end
    end

    // Write prev links and taken flags
    always_ff @(posedge clk)
    begin
        if (wr_en.prev_we)
        begin
            prev_mem[prev_addr] <= prev_wdata;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        rd_next_reg <= next_mem[rd_addr];
        rd_prev_reg <= prev_mem[rd_addr];
    end

    assign rd_next = rd_next_reg;
    assign rd_prev = rd_prev_reg;

endmodule

FILE: sv/opa_seq.sv
// Command sequencer: list heads, free count, link updates and list rebuild sweep.
module opa_seq #(
    parameter int POOL_DEPTH = opa_pkg::DEFAULT_POOL_DEPTH,
    localparam int IDX_W = $clog2(POOL_DEPTH),
    localparam int LNK_W = $clog2(POOL_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [opa_pkg::CMD_W-1:0]   command,
    input  logic [IDX_W-1:0]            item_index,
    input  logic [LNK_W-1:0]            item_count,
    output logic [IDX_W-1:0]            rd_addr,
    input  logic [LNK_W-1:0]            rd_next,
    input  logic [LNK_W:0]              rd_prev,
    output opa_pkg::opa_wr_en_t         wr_en,
    output logic [IDX_W-1:0]            next_addr,
    output logic [LNK_W-1:0]            next_wdata,
    output logic [IDX_W-1:0]            prev_addr,
    output logic [LNK_W:0]              prev_wdata,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [IDX_W-1:0]            res_slot,
    output logic [opa_pkg::ST_W-1:0]    res_status,
    output logic [LNK_W-1:0]            res_free
);
    import opa_pkg::*;

    localparam logic [LNK_W-1:0] NIL = LNK_W'(POOL_DEPTH);
    localparam int RESET_COUNT =
        (ITEM_COUNT_RESET > POOL_DEPTH) ? POOL_DEPTH : ITEM_COUNT_RESET;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_EXEC,
        S_LINK,
        S_HEAD,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic              op_alloc_reg, op_alloc_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [LNK_W-1:0]  link_p_reg, link_p_next;
    logic [LNK_W-1:0]  link_n_reg, link_n_next;
    logic [LNK_W-1:0]  link_h_reg, link_h_next;
    logic [LNK_W-1:0]  free_head_reg, free_head_next;
    logic [LNK_W-1:0]  taken_head_reg, taken_head_next;
    logic [LNK_W-1:0]  free_total_reg, free_total_next;
    logic [LNK_W-1:0]  active_reg, active_next;
    logic [LNK_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic              sweep_cmd_reg, sweep_cmd_next;
    logic [IDX_W-1:0]  res_slot_reg, res_slot_next;
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    logic [LNK_W-1:0]  res_free_reg, res_free_next;

    logic              accept;
    logic [LNK_W-1:0]  item_sat;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign item_sat = (item_count > NIL) ? NIL : item_count;

    // Read the free head for allocate, the named slot otherwise
    assign rd_addr = (command == CMD_ALLOC) ? free_head_reg[IDX_W-1:0] : item_index;

    // Next state, link writes and result
    always_comb
    begin
        state_next      = state_reg;
        op_alloc_next   = op_alloc_reg;
        slot_next       = slot_reg;
        link_p_next     = link_p_reg;
        link_n_next     = link_n_reg;
        link_h_next     = link_h_reg;
        free_head_next  = free_head_reg;
        taken_head_next = taken_head_reg;
        free_total_next = free_total_reg;
        active_next     = active_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        sweep_cmd_next  = sweep_cmd_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        res_free_next   = res_free_reg;
        wr_en           = '0;
        next_addr       = slot_reg;
        next_wdata      = free_head_reg;
        prev_addr       = slot_reg;
        prev_wdata      = {1'b0, NIL};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_slot_next   = '0;
                    res_status_next = ST_OK;
                    res_free_next   = free_total_reg;
                    op_alloc_next   = (command == CMD_ALLOC);
                    slot_next       = rd_addr;
                    case (command)
                        CMD_ALLOC:
                        begin
                            if (free_total_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_EXEC;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (LNK_W'(item_index) >= active_reg)
                            begin
                                res_status_next = ST_RANGE;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_EXEC;
                            end
                        end
                        CMD_FREE_ALL:
                        begin
                            active_next    = item_sat;
                            sweep_cnt_next = '0;
                            sweep_cmd_next = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            // Rebuild the free list one slot per cycle
            S_SWEEP:
            begin
                if (sweep_cnt_reg == active_reg)
                begin
                    free_head_next  = (active_reg == '0) ? NIL : active_reg - 1'b1;
                    taken_head_next = NIL;
                    free_total_next = active_reg;
                    res_free_next   = active_reg;
                    state_next      = sweep_cmd_reg ? S_FINISH : S_IDLE;
                end
                else
                begin
                    wr_en.next_we  = 1'b1;
                    wr_en.prev_we  = 1'b1;
                    next_addr      = sweep_cnt_reg[IDX_W-1:0];
                    prev_addr      = sweep_cnt_reg[IDX_W-1:0];
                    next_wdata     = (sweep_cnt_reg == '0) ? NIL : sweep_cnt_reg - 1'b1;
                    prev_wdata     = {1'b0, (sweep_cnt_reg == active_reg - 1'b1) ?
                                      NIL : sweep_cnt_reg + 1'b1};
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                end
            end

            // Use read data, write the slot itself and commit heads, or report a double free
            S_EXEC:
            begin
                if (op_alloc_reg)
                begin
                    wr_en.next_we   = 1'b1;
                    wr_en.prev_we   = 1'b1;
                    next_wdata      = taken_head_reg;
                    prev_wdata      = {1'b1, NIL};
                    link_n_next     = rd_next;
                    link_h_next     = taken_head_reg;
                    free_head_next  = rd_next;
                    taken_head_next = LNK_W'(slot_reg);
                    free_total_next = free_total_reg - 1'b1;
                    res_slot_next   = slot_reg;
                    res_free_next   = free_total_reg - 1'b1;
                    state_next      = S_LINK;
                end
                else if (!rd_prev[LNK_W])
                begin
                    res_status_next = ST_FREED;
                    state_next      = S_FINISH;
                end
                else
                begin
                    wr_en.next_we   = 1'b1;
                    wr_en.prev_we   = 1'b1;
                    next_wdata      = free_head_reg;
                    prev_wdata      = {1'b0, NIL};
                    link_p_next     = rd_prev[LNK_W-1:0];
                    link_n_next     = rd_next;
                    link_h_next     = free_head_reg;
                    free_head_next  = LNK_W'(slot_reg);
                    if (rd_prev[LNK_W-1:0] == NIL)
                    begin
                        taken_head_next = rd_next;
                    end
                    free_total_next = free_total_reg + 1'b1;
                    res_free_next   = free_total_reg + 1'b1;
                    state_next      = S_LINK;
                end
            end

            // Patch the neighbors of the slot
            S_LINK:
            begin
                if (op_alloc_reg)
                begin
                    wr_en.prev_we = (link_n_reg != NIL);
                    prev_addr     = link_n_reg[IDX_W-1:0];
                    prev_wdata    = {1'b0, NIL};
                end
                else
                begin
                    wr_en.next_we = (link_p_reg != NIL);
                    next_addr     = link_p_reg[IDX_W-1:0];
                    next_wdata    = link_n_reg;
                    wr_en.prev_we = (link_n_reg != NIL);
                    prev_addr     = link_n_reg[IDX_W-1:0];
                    prev_wdata    = {1'b1, link_p_reg};
                end
                state_next = S_HEAD;
            end

            // Point the old head of the target list back at the slot
            S_HEAD:
            begin
                wr_en.prev_we = (link_h_reg != NIL);
                prev_addr     = link_h_reg[IDX_W-1:0];
                prev_wdata    = {op_alloc_reg, LNK_W'(slot_reg)};
                state_next    = S_FINISH;
            end

            // Hold the result until the output stage takes it
            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            op_alloc_reg   <= 1'b0;
            slot_reg       <= '0;
            link_p_reg     <= NIL;
            link_n_reg     <= NIL;
            link_h_reg     <= NIL;
            free_head_reg  <= NIL;
            taken_head_reg <= NIL;
            free_total_reg <= '0;
            active_reg     <= LNK_W'(RESET_COUNT);
            sweep_cnt_reg  <= '0;
            sweep_cmd_reg  <= 1'b0;
            res_slot_reg   <= '0;
            res_status_reg <= ST_OK;
            res_free_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_alloc_reg   <= op_alloc_next;
            slot_reg       <= slot_next;
            link_p_reg     <= link_p_next;
            link_n_reg     <= link_n_next;
            link_h_reg     <= link_h_next;
            free_head_reg  <= free_head_next;
            taken_head_reg <= taken_head_next;
            free_total_reg <= free_total_next;
            active_reg     <= active_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            sweep_cmd_reg  <= sweep_cmd_next;
            res_slot_reg   <= res_slot_next;
            res_status_reg <= res_status_next;
            res_free_reg   <= res_free_next;
        end
    end

    assign res_valid  = (state_reg == S_FINISH);
    assign res_slot   = res_slot_reg;
    assign res_status = res_status_reg;
    assign res_free   = res_free_reg;

endmodule

FILE: sv/object_pool_allocator.sv
// Object pool allocator top level: slot count register, sequencer, link memories, output stage.
// Allocate and successful free: states exec, link, head and finish, then the output register; no new
// command is taken until idle again, paced by the single prev-link write port, three writes per command.
// Rejected or unknown commands go straight to finish (a double free through exec first), then the output register.
// Free-all: the sweep writes both link memories once per slot, for the latched slot count, then finishes.
// Reset: a rebuild pass over min(32, POOL_DEPTH) slots holds in_ready low; config writes are taken.
module object_pool_allocator #(
    parameter int POOL_DEPTH = opa_pkg::DEFAULT_POOL_DEPTH,
    localparam int IDX_W = $clog2(POOL_DEPTH),
    localparam int LNK_W = $clog2(POOL_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [LNK_W-1:0]            item_count,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [opa_pkg::CMD_W-1:0]   command,
    input  logic [IDX_W-1:0]            item_index,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [IDX_W-1:0]            slot_index,
    output logic [opa_pkg::ST_W-1:0]    status,
    output logic [LNK_W-1:0]            free_slots
);
    import opa_pkg::*;

    localparam int RESET_COUNT =
        (ITEM_COUNT_RESET > POOL_DEPTH) ? POOL_DEPTH : ITEM_COUNT_RESET;

    logic [LNK_W-1:0]  item_count_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  slot_index_reg;
    logic [ST_W-1:0]   status_reg;
    logic [LNK_W-1:0]  free_slots_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic [LNK_W-1:0]  rd_next;
    logic [LNK_W:0]    rd_prev;
    opa_wr_en_t        wr_en;
    logic [IDX_W-1:0]  next_addr;
    logic [LNK_W-1:0]  next_wdata;
    logic [IDX_W-1:0]  prev_addr;
    logic [LNK_W:0]    prev_wdata;
    logic              res_valid;
    logic              res_ready;
    logic [IDX_W-1:0]  res_slot;
    logic [ST_W-1:0]   res_status;
    logic [LNK_W-1:0]  res_free;

    // Capture slot count writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= LNK_W'(RESET_COUNT);
        end
        else if (cfg_wr_en)
        begin
            item_count_reg <= item_count;
        end
    end

    opa_seq #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .item_index (item_index),
        .item_count (item_count_reg),
        .rd_addr    (rd_addr),
        .rd_next    (rd_next),
        .rd_prev    (rd_prev),
        .wr_en      (wr_en),
        .next_addr  (next_addr),
        .next_wdata (next_wdata),
        .prev_addr  (prev_addr),
        .prev_wdata (prev_wdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_slot   (res_slot),
        .res_status (res_status),
        .res_free   (res_free)
    );

    opa_link_mem #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_link_mem (
        .clk        (clk),
        .wr_en      (wr_en),
        .next_addr  (next_addr),
        .next_wdata (next_wdata),
        .prev_addr  (prev_addr),
        .prev_wdata (prev_wdata),
        .rd_addr    (rd_addr),
        .rd_next    (rd_next),
        .rd_prev    (rd_prev)
    );

    // Output stage: take a new result when empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            slot_index_reg <= '0;
            status_reg     <= ST_OK;
            free_slots_reg <= '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                out_valid_reg  <= 1'b1;
                slot_index_reg <= res_slot;
                status_reg     <= res_status;
                free_slots_reg <= res_free;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot_index = slot_index_reg;
    assign status     = status_reg;
    assign free_slots = free_slots_reg;

`ifndef SYNTH
    // An accepted command drops in_ready in the cycle after the transfer
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while previous command still in flight");

    // Free count never exceeds the pool
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (free_slots <= LNK_W'(POOL_DEPTH)))
        else $error("free count above pool depth");

    // Only a successful allocate reports a slot
    a_slot_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (slot_index == '0))
        else $error("slot index set on a rejected command");

    // Empty pool means no free slots
    a_empty_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (free_slots == '0))
        else $error("pool empty reported with free slots left");
`endif

endmodule

FILE: tb/sv/object_pool_allocator_test.sv
// Self-checking testbench for the object pool allocator: directed and random commands.
module object_pool_allocator_test;

    import opa_pkg::*;

    localparam int DEPTH = DEFAULT_POOL_DEPTH;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int LNK_W = $clog2(DEPTH + 1);
    localparam logic [LNK_W-1:0] NIL = LNK_W'(DEPTH);
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [IDX_W-1:0] slot;
        logic [ST_W-1:0]  status;
        logic [LNK_W-1:0] free_count;
    } pool_result_t;

    // Pool model with its own link memories, plus the queue of expected results
    class pool_scoreboard;
        logic [LNK_W-1:0] next_lnk [DEPTH];
        logic [LNK_W-1:0] prev_lnk [DEPTH];
        bit               taken    [DEPTH];
        logic [LNK_W-1:0] free_head;
        logic [LNK_W-1:0] taken_head;
        logic [LNK_W-1:0] free_total;
        logic [LNK_W-1:0] active_slots;
        logic [LNK_W-1:0] count_reg;
        pool_result_t     expected_q[$];
        int               failures;
        int               commands;
        int               results;
        int               status_seen[4];

        function void reset_pool();
            count_reg = LNK_W'(ITEM_COUNT_RESET);
            failures  = 0;
            commands  = 0;
            results   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            expected_q.delete();
            rebuild();
        endfunction

        function void set_count(logic [LNK_W-1:0] v);
            count_reg = v;
        endfunction

        function void push_free(logic [LNK_W-1:0] s);
            next_lnk[s] = free_head;
            prev_lnk[s] = NIL;
            if (free_head != NIL)
                prev_lnk[free_head] = s;
            free_head = s;
            taken[s] = 1'b0;
            free_total++;
        endfunction

        // Latch the slot count, saturated to the depth, and refill the free list
        function void rebuild();
            active_slots = (count_reg > NIL) ? NIL : count_reg;
            free_head = NIL;
            taken_head = NIL;
            free_total = '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                next_lnk[i] = NIL;
                prev_lnk[i] = NIL;
                taken[i] = 1'b0;
            end
            for (int i = 0; i < DEPTH; i++)
                if (i < active_slots)
                    push_free(LNK_W'(i));
        endfunction

        // Advance the model by one accepted command and queue its result
        function void note_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx);
            pool_result_t r;
            logic [LNK_W-1:0] s;
            logic [LNK_W-1:0] p;
            logic [LNK_W-1:0] n;
            r = '0;
            commands++;
            case (cmd)
                CMD_ALLOC:
                begin
                    if (free_total == 0 || free_head == NIL)
                        r.status = ST_EMPTY;
                    else
                    begin
                        s = free_head;
                        free_head = next_lnk[s];
                        if (free_head != NIL)
                            prev_lnk[free_head] = NIL;
                        next_lnk[s] = taken_head;
                        if (taken_head != NIL)
                            prev_lnk[taken_head] = s;
                        prev_lnk[s] = NIL;
                        taken_head = s;
                        taken[s] = 1'b1;
                        free_total--;
                        r.slot = s[IDX_W-1:0];
                    end
                end
                CMD_FREE:
                begin
                    if ({1'b0, idx} >= active_slots)
                        r.status = ST_RANGE;
                    else if (!taken[idx])
                        r.status = ST_FREED;
                    else
                    begin
                        p = prev_lnk[idx];
                        n = next_lnk[idx];
                        if (p != NIL)
                            next_lnk[p] = n;
                        else
                            taken_head = n;
                        if (n != NIL)
                            prev_lnk[n] = p;
                        push_free({1'b0, idx});
                    end
                end
                CMD_FREE_ALL: rebuild();
                default: ;
            endcase
            r.free_count = free_total;
            expected_q.push_back(r);
        endfunction

        // Compare one result transfer against the oldest expectation
        function void check_result(logic [IDX_W-1:0] slot, logic [ST_W-1:0] st,
                                   logic [LNK_W-1:0] fr);
            pool_result_t e;
            results++;
            status_seen[st]++;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result with nothing pending: slot=%0d status=%0d free=%0d",
                             slot, st, fr);
                return;
            end
            e = expected_q.pop_front();
            if (slot !== e.slot || st !== e.status || fr !== e.free_count)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result %0d: slot %0d/%0d status %0d/%0d free %0d/%0d (exp/act)",
                             results, e.slot, slot, e.status, st, e.free_count, fr);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Choose a random slot that is currently handed out, or -1 when none is
        function int pick_taken();
            int cand[$];
            for (int i = 0; i < DEPTH; i++)
                if (taken[i])
                    cand.push_back(i);
            if (cand.size() == 0)
                return -1;
            return cand[$urandom_range(cand.size() - 1)];
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [LNK_W-1:0] item_count = LNK_W'(ITEM_COUNT_RESET);
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [CMD_W-1:0] command = CMD_ALLOC;
    logic [IDX_W-1:0] item_index = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [IDX_W-1:0] slot_index;
    logic [ST_W-1:0]  status;
    logic [LNK_W-1:0] free_slots;

    pool_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit long_hold_req = 1'b0;
    int hold_left = 0;
    int cycles = 0;
    int settings = 0;

    object_pool_allocator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .item_count (item_count),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .item_index (item_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .slot_index (slot_index),
        .status     (status),
        .free_slots (free_slots)
    );

    always #10 clk = ~clk;

    // Watch both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_command(command, item_index);
        if (rst_n && out_valid && out_ready)
            sb.check_result(slot_index, status, free_slots);
    end

    // Drive out_ready; a long hold-off request holds it low while hold_left counts down from LONG_HOLD
    always @(negedge clk)
    begin
        if (long_hold_req && hold_left == 0)
        begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d results pending", cycles, sb.pending());
            $display("** object_pool_allocator: FAILED **");
            $finish;
        end
    end

    // Offer one command and hold it until the input transfer; return at a falling edge
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        item_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid, wait until the pool is idle, then write the slot count register
    task automatic write_count(logic [LNK_W-1:0] v);
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        cfg_wr_en  <= 1'b1;
        item_count <= v;
        sb.set_count(v);
        settings++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int roll;
        int alloc_pct;
        int pick;
        int leftover;
        logic [LNK_W-1:0] cnt;

        sb = new();
        sb.reset_pool();

        // Hold reset, then release at a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: full pool after reset, double free, unknown command
        send_item(CMD_ALLOC, 5'd0);
        send_item(CMD_FREE, 5'd31);
        send_item(CMD_FREE, 5'd31);
        send_item(CMD_FREE, 5'd0);
        send_item(CMD_UNUSED, 5'd31);
        send_item(CMD_ALLOC, 5'd31);
        send_item(CMD_ALLOC, 5'd0);
        send_item(CMD_FREE_ALL, 5'd31);

        // Directed: single slot, empty pool and out-of-range frees
        write_count(6'd1);
        send_item(CMD_FREE_ALL, 5'd0);
        send_item(CMD_ALLOC, 5'd0);
        send_item(CMD_ALLOC, 5'd0);
        send_item(CMD_FREE, 5'd1);
        send_item(CMD_FREE, 5'd31);
        send_item(CMD_FREE, 5'd0);
        send_item(CMD_FREE, 5'd0);

        // Directed: no slots at all
        write_count(6'd0);
        send_item(CMD_FREE_ALL, 5'd0);
        send_item(CMD_ALLOC, 5'd0);
        send_item(CMD_FREE, 5'd0);

        // Directed: count above depth saturates
        write_count(6'd63);
        send_item(CMD_FREE_ALL, 5'd0);
        send_item(CMD_ALLOC, 5'd0);
        send_item(CMD_FREE, 5'd31);

        // Random: three idle profiles, six slot-count settings each
        for (int stage = 0; stage < 3; stage++)
        begin
            case (stage)
                0: begin send_idle_pct = 30; recv_idle_pct = 86; end
                1: begin send_idle_pct = 86; recv_idle_pct = 30; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int ph = 0; ph < 6; ph++)
            begin
                pick = $urandom_range(5);
                case (pick)
                    0: cnt = 6'd32;
                    1: cnt = 6'd1;
                    2: cnt = 6'd2;
                    3: cnt = LNK_W'($urandom_range(63, 33));
                    default: cnt = LNK_W'($urandom_range(32, 1));
                endcase
                write_count(cnt);
                send_item(CMD_FREE_ALL, IDX_W'($urandom_range(31)));
                if (stage == 2 && ph == 1)
                    long_hold_req = 1'b1;
                alloc_pct = $urandom_range(75, 35);
                for (int k = 0; k < 50; k++)
                begin
                    roll = $urandom_range(99);
                    if (roll < alloc_pct)
                        send_item(CMD_ALLOC, IDX_W'($urandom_range(31)));
                    else if (roll < 92)
                    begin
                        pick = sb.pick_taken();
                        if (pick < 0)
                            pick = $urandom_range(31);
                        send_item(CMD_FREE, IDX_W'(pick));
                    end
                    else if (roll < 95)
                        send_item(CMD_FREE, IDX_W'($urandom_range(31)));
                    else if (roll < 98)
                        send_item(CMD_FREE_ALL, IDX_W'($urandom_range(31)));
                    else
                        send_item(CMD_UNUSED, IDX_W'($urandom_range(31)));
                end
            end
        end

        // Drain outstanding results, then allow for a full rebuild
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        leftover = sb.pending();
        if (leftover != 0)
            $display("ERROR: %0d expected results never arrived", leftover);
        $display("Ran %0d commands over %0d slot-count settings in %0d cycles, %0d mismatches.",
                 sb.commands, settings, cycles, sb.failures);
        $display("Statuses seen: ok %0d, empty %0d, out of range %0d, already free %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
                 sb.status_seen[ST_RANGE], sb.status_seen[ST_FREED]);
        if (sb.failures == 0 && leftover == 0)
            $display("** object_pool_allocator: PASSED **");
        else
            $display("** object_pool_allocator: FAILED **");
        $finish;
    end

endmodule
